>>> hdl/aslr_pkg.sv
// ----------------------------------------------------------------------------
// aslr_pkg
// Shared types and codes for the AT status line recognizer.
// ----------------------------------------------------------------------------
package aslr_pkg;

	// longest value kept for a SIM status line
	localparam int VALUE_CHARS = 8;
	localparam int LEN_W = $clog2(VALUE_CHARS + 2);
	localparam int IDX_W = $clog2(VALUE_CHARS);

	typedef logic [LEN_W-1:0] len_t;
	typedef logic [IDX_W-1:0] idx_t;

	// input item kinds
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_BEGIN = 2'd2;

	// report kinds
	localparam logic [1:0] RPT_SIM     = 2'd0;
	localparam logic [1:0] RPT_REG     = 2'd1;
	localparam logic [1:0] RPT_TIMEOUT = 2'd2;

	// SIM status codes
	localparam logic [1:0] SIM_READY = 2'd0;
	localparam logic [1:0] SIM_PIN   = 2'd1;
	localparam logic [1:0] SIM_PUK   = 2'd2;
	localparam logic [1:0] SIM_OTHER = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  rx_byte;
		logic [31:0] deadline_ms;
	} in_word_t;

	typedef struct packed {
		logic [1:0] report_kind;
		logic [1:0] sim_status;
		logic       registered;
	} out_word_t;

	// decoded item in the work stage plus commit strobe
	typedef struct packed {
		logic byte_vld;
		logic tick_vld;
		logic begin_vld;
		logic commit;
	} ctl_t;

	// line parser finding for the current item
	typedef struct packed {
		logic       done;
		logic       is_reg;
		logic [1:0] sim;
		logic       registered;
	} line_rpt_t;

endpackage

>>> hdl/at_status_line_recognizer_top.sv
// ----------------------------------------------------------------------------
// at_status_line_recognizer_top
// Recognizes +CPIN: and +CREG:/+CEREG: lines in a modem byte stream and
// reports them at end of line; also runs a millisecond response deadline.
// ----------------------------------------------------------------------------
// Takes one word per clock: a received byte, a millisecond tick or a begin
// word that arms the deadline. Each word is registered into a single work
// stage, evaluated there against the line and timer state, and any report
// lands in an output register. Sustained rate is one word per cycle. A word
// that yields no report retires even while an earlier report sits unclaimed
// in the output register; only a reporting word waits for that register to
// free up, so the input stalls only then. A report comes on CR or LF ending
// a SIM status line (READY, SIM PIN, SIM PUK or other) or a registration
// line (registered when ",1" or ",5" appears in it), or once on deadline
// expiry. Kind 3 words are accepted and dropped.
// ----------------------------------------------------------------------------
module at_status_line_recognizer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  aslr_pkg::in_word_t  item,
	output logic                report_valid,
	input  logic                report_stall,
	output aslr_pkg::out_word_t report
);

	logic                valid_s1;
	aslr_pkg::in_word_t  word_s1;
	aslr_pkg::ctl_t      ctl;
	aslr_pkg::line_rpt_t line_rpt;
	logic                tmr_fire;
	logic                produces;
	logic                out_free;
	logic                adv;
	logic                out_valid_q;
	aslr_pkg::out_word_t out_q;
	aslr_pkg::out_word_t result;

	// work stage advances unless it has a report and the output is full
	assign produces   = line_rpt.done || tmr_fire;
	assign out_free   = !out_valid_q || !report_stall;
	assign adv        = valid_s1 && (!produces || out_free);
	assign item_stall = valid_s1 && !adv;

	assign ctl.byte_vld  = valid_s1 && (word_s1.kind == aslr_pkg::KIND_BYTE);
	assign ctl.tick_vld  = valid_s1 && (word_s1.kind == aslr_pkg::KIND_TICK);
	assign ctl.begin_vld = valid_s1 && (word_s1.kind == aslr_pkg::KIND_BEGIN);
	assign ctl.commit    = adv;

	aslr_line u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rx_byte (word_s1.rx_byte),
		.rpt     (line_rpt)
	);

	aslr_timer u_timer (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.deadline_ms (word_s1.deadline_ms),
		.line_done   (line_rpt.done),
		.fire        (tmr_fire)
	);

	// line and timer reports never coincide: one word, one source
	always_comb begin
		result = '0;
		if (line_rpt.done) begin
			result.report_kind = line_rpt.is_reg ? aslr_pkg::RPT_REG : aslr_pkg::RPT_SIM;
			result.sim_status  = line_rpt.sim;
			result.registered  = line_rpt.registered;
		end else begin
			result.report_kind = aslr_pkg::RPT_TIMEOUT;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			word_s1 <= item;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && produces) begin
			out_valid_q <= 1'b1;
		end else if (!report_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && produces) begin
			out_q <= result;
		end
	end

	assign report_valid = out_valid_q;
	assign report       = out_q;

endmodule

>>> hdl/aslr_line.sv
// ----------------------------------------------------------------------------
// aslr_line
// Tag matchers and line collector: finds +CPIN:/+CREG:/+CEREG:, collects a
// SIM value or registration marks and classifies the line at CR or LF.
// ----------------------------------------------------------------------------
module aslr_line (
	input  logic                clk,
	input  logic                arst_n,
	input  aslr_pkg::ctl_t      ctl,
	input  logic [7:0]          rx_byte,
	output aslr_pkg::line_rpt_t rpt
);

	typedef enum logic [1:0] {
		MODE_SEARCH = 2'd0,
		MODE_SIM    = 2'd1,
		MODE_REG    = 2'd2
	} mode_t;

	// tags padded to eight entries so a 3-bit position always indexes
	localparam logic [7:0] TAG_CPIN [8] = '{"+", "C", "P", "I", "N", ":", 8'h00, 8'h00};
	localparam logic [7:0] TAG_CREG [8] = '{"+", "C", "R", "E", "G", ":", 8'h00, 8'h00};
	localparam logic [7:0] TAG_CEREG [8] = '{"+", "C", "E", "R", "E", "G", ":", 8'h00};
	localparam logic [7:0] W_READY [5] = '{"R", "E", "A", "D", "Y"};
	localparam logic [7:0] W_PIN [7] = '{"S", "I", "M", " ", "P", "I", "N"};
	localparam logic [7:0] W_PUK [7] = '{"S", "I", "M", " ", "P", "U", "K"};

	mode_t              mode_q, mode_n;
	logic [2:0]         cpin_pos_q, cpin_pos_n;
	logic [2:0]         creg_pos_q, creg_pos_n;
	logic [2:0]         cereg_pos_q, cereg_pos_n;
	aslr_pkg::len_t     len_q, len_n;
	aslr_pkg::len_t     trim_q, trim_n;
	logic               comma_q, comma_n;
	logic               reg_q, reg_n;
	logic [7:0]         chars_q [aslr_pkg::VALUE_CHARS];
	logic               wr_en;
	logic               eol, blank;
	logic               hit_ready, hit_pin, hit_puk;
	logic [1:0]         sim_code;

	function automatic logic [2:0] match_step(input logic [2:0] pos, input logic [7:0] tc,
		input logic [2:0] len, input logic [7:0] b);
		if (pos < len && tc == b) begin
			return pos + 3'd1;
		end
		return (b == "+") ? 3'd1 : 3'd0;
	endfunction

	assign eol   = (rx_byte == 8'h0D) || (rx_byte == 8'h0A);
	assign blank = (rx_byte == 8'h20) || (rx_byte == 8'h09);

	// value classification; entries below trim_q are always written
	always_comb begin
		hit_ready = (trim_q == aslr_pkg::len_t'(5));
		hit_pin   = (trim_q == aslr_pkg::len_t'(7));
		hit_puk   = (trim_q == aslr_pkg::len_t'(7));
		for (int i = 0; i < 5; i++) begin
			hit_ready = hit_ready && (chars_q[i] == W_READY[i]);
		end
		for (int i = 0; i < 7; i++) begin
			hit_pin = hit_pin && (chars_q[i] == W_PIN[i]);
			hit_puk = hit_puk && (chars_q[i] == W_PUK[i]);
		end
		priority if (hit_ready) begin
			sim_code = aslr_pkg::SIM_READY;
		end else if (hit_pin) begin
			sim_code = aslr_pkg::SIM_PIN;
		end else if (hit_puk) begin
			sim_code = aslr_pkg::SIM_PUK;
		end else begin
			sim_code = aslr_pkg::SIM_OTHER;
		end
	end

	always_comb begin
		mode_n      = mode_q;
		cpin_pos_n  = cpin_pos_q;
		creg_pos_n  = creg_pos_q;
		cereg_pos_n = cereg_pos_q;
		len_n       = len_q;
		trim_n      = trim_q;
		comma_n     = comma_q;
		reg_n       = reg_q;
		wr_en       = 1'b0;
		rpt         = '0;
		if (ctl.begin_vld) begin
			mode_n      = MODE_SEARCH;
			cpin_pos_n  = '0;
			creg_pos_n  = '0;
			cereg_pos_n = '0;
			len_n       = '0;
			trim_n      = '0;
			comma_n     = 1'b0;
			reg_n       = 1'b0;
		end else if (ctl.byte_vld) begin
			unique case (mode_q)
				MODE_SIM, MODE_REG: begin
					if (eol) begin
						rpt.done       = 1'b1;
						rpt.is_reg     = (mode_q == MODE_REG);
						rpt.sim        = (mode_q == MODE_SIM) ? sim_code : aslr_pkg::SIM_READY;
						rpt.registered = (mode_q == MODE_REG) && reg_q;
						mode_n         = MODE_SEARCH;
						cpin_pos_n     = '0;
						creg_pos_n     = '0;
						cereg_pos_n    = '0;
						len_n          = '0;
						trim_n         = '0;
						comma_n        = 1'b0;
						reg_n          = 1'b0;
					end else if (mode_q == MODE_REG) begin
						if (comma_q && (rx_byte == "1" || rx_byte == "5")) begin
							reg_n = 1'b1;
						end
						comma_n = (rx_byte == ",");
					end else if (!(blank && len_q == '0)) begin
						wr_en = (len_q < aslr_pkg::len_t'(aslr_pkg::VALUE_CHARS));
						// length saturates one past the store
						if (len_q <= aslr_pkg::len_t'(aslr_pkg::VALUE_CHARS)) begin
							len_n = len_q + aslr_pkg::len_t'(1);
						end
						if (!blank) begin
							trim_n = len_n;
						end
					end
				end
				MODE_SEARCH: begin
					cpin_pos_n  = match_step(cpin_pos_q, TAG_CPIN[cpin_pos_q], 3'd6, rx_byte);
					creg_pos_n  = match_step(creg_pos_q, TAG_CREG[creg_pos_q], 3'd6, rx_byte);
					cereg_pos_n = match_step(cereg_pos_q, TAG_CEREG[cereg_pos_q], 3'd7, rx_byte);
					if (cpin_pos_n == 3'd6 || creg_pos_n == 3'd6 || cereg_pos_n == 3'd7) begin
						mode_n      = (cpin_pos_n == 3'd6) ? MODE_SIM : MODE_REG;
						cpin_pos_n  = '0;
						creg_pos_n  = '0;
						cereg_pos_n = '0;
						len_n       = '0;
						trim_n      = '0;
						comma_n     = 1'b0;
						reg_n       = 1'b0;
					end
				end
				default: begin
					mode_n = MODE_SEARCH;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_SEARCH;
			cpin_pos_q  <= '0;
			creg_pos_q  <= '0;
			cereg_pos_q <= '0;
			len_q       <= '0;
			trim_q      <= '0;
			comma_q     <= 1'b0;
			reg_q       <= 1'b0;
		end else if (ctl.commit) begin
			mode_q      <= mode_n;
			cpin_pos_q  <= cpin_pos_n;
			creg_pos_q  <= creg_pos_n;
			cereg_pos_q <= cereg_pos_n;
			len_q       <= len_n;
			trim_q      <= trim_n;
			comma_q     <= comma_n;
			reg_q       <= reg_n;
		end
	end

	// value bytes: payload only, read back below trim_q
	always_ff @(posedge clk) begin
		if (ctl.commit && wr_en) begin
			chars_q[len_q[aslr_pkg::IDX_W-1:0]] <= rx_byte;
		end
	end

endmodule

>>> hdl/aslr_timer.sv
// ----------------------------------------------------------------------------
// aslr_timer
// Millisecond deadline: armed by a begin word, fires once on expiry.
// ----------------------------------------------------------------------------
module aslr_timer (
	input  logic           clk,
	input  logic           arst_n,
	input  aslr_pkg::ctl_t ctl,
	input  logic [31:0]    deadline_ms,
	input  logic           line_done,
	output logic           fire
);

	logic [31:0] elapsed_q, elapsed_n;
	logic [31:0] deadline_q;
	logic        waiting_q;

	// saturating count
	assign elapsed_n = (elapsed_q != '1) ? elapsed_q + 32'd1 : elapsed_q;

	always_comb begin
		fire = 1'b0;
		if (ctl.begin_vld) begin
			fire = (deadline_ms == '0);
		end else if (ctl.tick_vld) begin
			fire = waiting_q && (elapsed_n >= deadline_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q  <= '0;
			deadline_q <= '0;
			waiting_q  <= 1'b0;
		end else if (ctl.commit) begin
			if (ctl.begin_vld) begin
				elapsed_q  <= '0;
				deadline_q <= deadline_ms;
				waiting_q  <= (deadline_ms != '0);
			end else if (ctl.tick_vld && waiting_q) begin
				elapsed_q <= elapsed_n;
				if (fire) begin
					waiting_q <= 1'b0;
				end
			end else if (line_done) begin
				waiting_q <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/aslr_checker.sv
// ----------------------------------------------------------------------------
// aslr_checker
// Port-level checks for the AT status line recognizer, bound to the top.
// ----------------------------------------------------------------------------
module aslr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_stall,
	input aslr_pkg::in_word_t  item,
	input logic                report_valid,
	input logic                report_stall,
	input aslr_pkg::out_word_t report
);

	// stalled report holds
	a_report_hold: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report_stall |=> report_valid && $stable(report))
		else $error("report changed while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |-> (report.report_kind == aslr_pkg::RPT_SIM ||
		report.report_kind == aslr_pkg::RPT_REG ||
		report.report_kind == aslr_pkg::RPT_TIMEOUT))
		else $error("illegal report kind");

	a_timeout_clean: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report.report_kind == aslr_pkg::RPT_TIMEOUT
		|-> report.sim_status == aslr_pkg::SIM_READY && !report.registered)
		else $error("timeout report carries line fields");

	a_fields_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |-> !(report.registered && report.report_kind != aslr_pkg::RPT_REG) &&
		!(report.sim_status != aslr_pkg::SIM_READY && report.report_kind != aslr_pkg::RPT_SIM))
		else $error("report fields mixed between kinds");

	// no pending report on the output: input never stalls
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!report_valid |-> !item_stall)
		else $error("input stalled with empty output register");

endmodule

bind at_status_line_recognizer_top aslr_checker u_aslr_checker (.*);

>>> sim/aslr_report_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aslr_report_checker
// Watches both channels of the status line recognizer, predicts each report
// word from the accepted input words and compares field by field.
// ----------------------------------------------------------------------------
module aslr_report_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_stall,
	input  aslr_pkg::in_word_t  item,
	input  logic                report_valid,
	input  logic                report_stall,
	input  aslr_pkg::out_word_t report,
	input  logic                run_over,
	output int                  fails,
	output int                  pending
);
	import aslr_pkg::*;

	localparam logic [1:0] LINE_SEARCH = 2'd0;
	localparam logic [1:0] LINE_SIM    = 2'd1;
	localparam logic [1:0] LINE_REG    = 2'd2;

	localparam logic [0:6][7:0] TAG_CPIN   = {"+CPIN:", 8'h00};
	localparam logic [0:6][7:0] TAG_CREG   = {"+CREG:", 8'h00};
	localparam logic [0:6][7:0] TAG_CEREG  = "+CEREG:";
	localparam logic [0:6][7:0] WORD_READY = {"READY", 16'h0000};
	localparam logic [0:6][7:0] WORD_PIN   = "SIM PIN";
	localparam logic [0:6][7:0] WORD_PUK   = "SIM PUK";

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_COMMA = ",";
	localparam logic [7:0] CH_ONE   = "1";
	localparam logic [7:0] CH_FIVE  = "5";

	// predicted block state
	logic [2:0]  cpin_pos, creg_pos, cereg_pos;
	logic [1:0]  line_mode;
	logic [7:0]  value_buf [VALUE_CHARS];
	len_t        value_len, trim_len;
	logic        after_comma, reg_seen;
	logic [31:0] ms_elapsed, ms_deadline;
	logic        deadline_armed;

	out_word_t   expected_reports [$];
	out_word_t   want, predicted;
	bit          has_report;
	bit          leftover_checked = 1'b0;

	initial begin
		fails   = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		fails++;
	endtask

	function automatic logic [2:0] tag_step(input logic [2:0] pos,
			input logic [0:6][7:0] tag, input int tag_len, input logic [7:0] b);
		if (pos < tag_len && tag[pos] == b)
			return pos + 3'd1;
		return (b == CH_PLUS) ? 3'd1 : 3'd0;
	endfunction

	function automatic bit value_equals(input logic [0:6][7:0] w, input int w_len);
		bit same;
		same = (trim_len == w_len);
		for (int i = 0; i < w_len; i++)
			if (same && value_buf[i] != w[i])
				same = 1'b0;
		return same;
	endfunction

	task automatic clear_line();
		cpin_pos    = '0;
		creg_pos    = '0;
		cereg_pos   = '0;
		line_mode   = LINE_SEARCH;
		value_len   = '0;
		trim_len    = '0;
		after_comma = 1'b0;
		reg_seen    = 1'b0;
	endtask

	task automatic predict_report(input in_word_t w, output bit hit, output out_word_t r);
		logic [7:0] b;
		bit         eol, blank;
		logic [1:0] sim;
		hit   = 1'b0;
		r     = '0;
		b     = w.rx_byte;
		eol   = (b == CH_CR || b == CH_LF);
		blank = (b == CH_SPACE || b == CH_TAB);
		case (w.kind)
			KIND_BYTE: begin
				if (line_mode == LINE_SIM) begin
					if (eol) begin
						sim = SIM_OTHER;
						if (value_equals(WORD_READY, 5))
							sim = SIM_READY;
						else if (value_equals(WORD_PIN, 7))
							sim = SIM_PIN;
						else if (value_equals(WORD_PUK, 7))
							sim = SIM_PUK;
						clear_line();
						deadline_armed = 1'b0;
						hit = 1'b1;
						r.report_kind = RPT_SIM;
						r.sim_status  = sim;
					end else if (!(blank && value_len == 0)) begin
						if (value_len < VALUE_CHARS)
							value_buf[value_len] = b;
						if (value_len <= VALUE_CHARS)
							value_len++;
						if (!blank)
							trim_len = value_len;
					end
				end else if (line_mode == LINE_REG) begin
					if (eol) begin
						hit = 1'b1;
						r.report_kind = RPT_REG;
						r.registered  = reg_seen;
						clear_line();
						deadline_armed = 1'b0;
					end else begin
						if (after_comma && (b == CH_ONE || b == CH_FIVE))
							reg_seen = 1'b1;
						after_comma = (b == CH_COMMA);
					end
				end else begin
					cpin_pos  = tag_step(cpin_pos, TAG_CPIN, 6, b);
					creg_pos  = tag_step(creg_pos, TAG_CREG, 6, b);
					cereg_pos = tag_step(cereg_pos, TAG_CEREG, 7, b);
					if (cpin_pos == 3'd6) begin
						clear_line();
						line_mode = LINE_SIM;
					end else if (creg_pos == 3'd6 || cereg_pos == 3'd7) begin
						clear_line();
						line_mode = LINE_REG;
					end
				end
			end
			KIND_TICK: begin
				if (deadline_armed) begin
					if (ms_elapsed != '1)
						ms_elapsed++;
					if (ms_elapsed >= ms_deadline) begin
						deadline_armed = 1'b0;
						hit = 1'b1;
						r.report_kind = RPT_TIMEOUT;
					end
				end
			end
			KIND_BEGIN: begin
				clear_line();
				ms_elapsed  = '0;
				ms_deadline = w.deadline_ms;
				if (ms_deadline == '0) begin
					deadline_armed = 1'b0;
					hit = 1'b1;
					r.report_kind = RPT_TIMEOUT;
				end else begin
					deadline_armed = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_line();
			ms_elapsed     = '0;
			ms_deadline    = '0;
			deadline_armed = 1'b0;
		end else begin
			if (report_valid && !report_stall) begin
				if (expected_reports.size() == 0) begin
					report_mismatch($sformatf("report word %h with none expected", report));
				end else begin
					want = expected_reports.pop_front();
					if (report.report_kind !== want.report_kind)
						report_mismatch($sformatf("report_kind %h, expected %h",
							report.report_kind, want.report_kind));
					if (report.sim_status !== want.sim_status)
						report_mismatch($sformatf("sim_status %h, expected %h",
							report.sim_status, want.sim_status));
					if (report.registered !== want.registered)
						report_mismatch($sformatf("registered %b, expected %b",
							report.registered, want.registered));
				end
			end
			if (item_valid && !item_stall) begin
				predict_report(item, has_report, predicted);
				if (has_report)
					expected_reports.push_back(predicted);
			end
			pending = expected_reports.size();
			if (run_over && !leftover_checked) begin
				leftover_checked = 1'b1;
				if (expected_reports.size() != 0)
					report_mismatch($sformatf("%0d expected report words never came",
						expected_reports.size()));
			end
		end
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the AT status line recognizer.
// ----------------------------------------------------------------------------
// Feeds SIM status lines, registration lines, deadline begin/tick words and
// noise through the input channel while stalling the report channel at
// random; the checker beside the block predicts and compares every report.
// ----------------------------------------------------------------------------
module testbench;
	import aslr_pkg::*;

	// kind code the block accepts and drops
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [7:0] CH_CR       = 8'h0d;
	localparam logic [7:0] CH_LF       = 8'h0a;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	// report side hold-off used to back the block up into its input
	localparam int LONG_HOLD = 200;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	in_word_t  item;
	logic      report_valid;
	logic      report_stall;
	out_word_t report;
	logic      run_over;

	int fails, pending;
	int idle_pct   = 0;
	int stall_pct  = 0;
	int words_sent = 0;
	bit hold_go    = 1'b0;
	int hold_left  = 0;
	int drain_cycles;

	at_status_line_recognizer_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report       (report)
	);

	aslr_report_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report       (report),
		.run_over     (run_over),
		.fails        (fails),
		.pending      (pending)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// hard stop if the run hangs
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// Report side: random stall at stall_pct, or a long hold-off when asked.
	// Requests and the percentage are picked up at the rising edge, the stall
	// itself changes at the falling edge.
	initial begin
		int pct_now;
		report_stall = 1'b0;
		pct_now = 0;
		forever begin
			@(posedge clk);
			pct_now = stall_pct;
			if (hold_go) begin
				hold_go   = 1'b0;
				hold_left = LONG_HOLD;
			end
			@(negedge clk);
			if (hold_left != 0) begin
				report_stall <= 1'b1;
				hold_left--;
			end else begin
				report_stall <= ($urandom_range(99) < pct_now);
			end
		end
	end

	// One input word. Called at a falling edge; returns at the falling edge
	// after the word was taken, with valid still high so a following word
	// can go out back to back.
	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		do
			@(posedge clk);
		while (item_stall);
		@(negedge clk);
		if (w.kind != KIND_UNUSED)
			words_sent++;
	endtask

	// unused fields carry junk so every bit gets exercised
	task automatic send_byte(input logic [7:0] b);
		send_word('{KIND_BYTE, b, $urandom});
	endtask

	task automatic send_tick();
		send_word('{KIND_TICK, 8'($urandom), $urandom});
	endtask

	task automatic send_begin(input logic [31:0] ms);
		send_word('{KIND_BEGIN, 8'($urandom), ms});
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_blanks(input int n);
		for (int i = 0; i < n; i++)
			send_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
	endtask

	// mostly value-like characters, now and then any byte (CR/LF included)
	function automatic logic [7:0] value_char();
		string pool;
		pool = "ABCDEIKMNPRSUY0159, \t+:";
		if ($urandom_range(15) == 0)
			return 8'($urandom);
		return pool[$urandom_range(pool.len() - 1)];
	endfunction

	task automatic send_line_end();
		case ($urandom_range(2))
			0: send_byte(CH_CR);
			1: send_byte(CH_LF);
			default: begin
				send_byte(CH_CR);
				send_byte(CH_LF);
			end
		endcase
	endtask

	// +CPIN: line: known words, near misses, empty, random and overlong values
	task automatic send_sim_line();
		int n;
		if ($urandom_range(4) == 0)
			send_text("AT");
		send_text("+CPIN:");
		send_blanks($urandom_range(2));
		case ($urandom_range(9))
			0, 1: send_text("READY");
			2, 3: send_text("SIM PIN");
			4:    send_text("SIM PUK");
			5:    ;
			6: begin
				case ($urandom_range(7))
					0: send_text("READ");
					1: send_text("READYY");
					2: send_text("SIM PIX");
					3: send_text("SIM PU");
					4: send_text("SIM  PIN");
					5: send_text("ready");
					6: send_text("+CREG:,1");
					default: send_text("SIM PUK\tX");
				endcase
			end
			7: begin
				n = $urandom_range(12, 8);
				for (int i = 0; i < n; i++)
					send_byte(value_char());
			end
			default: begin
				n = $urandom_range(7, 1);
				for (int i = 0; i < n; i++)
					send_byte(value_char());
			end
		endcase
		send_blanks($urandom_range(2));
		send_line_end();
	endtask

	// +CREG:/+CEREG: line with digits, commas and blanks
	task automatic send_reg_line();
		string pool;
		int    n;
		pool = " ,,,0123456789";
		send_text($urandom_range(1) ? "+CREG:" : "+CEREG:");
		n = $urandom_range(8);
		for (int i = 0; i < n; i++)
			if ($urandom_range(15) == 0)
				send_byte(8'($urandom));
			else
				send_byte(pool[$urandom_range(pool.len() - 1)]);
		send_line_end();
	endtask

	// short deadlines so ticks actually run them out
	task automatic send_timer_burst();
		int n;
		send_begin(($urandom_range(3) == 0) ? $urandom : $urandom_range(10));
		n = $urandom_range(12);
		for (int i = 0; i < n; i++) begin
			send_tick();
			if ($urandom_range(7) == 0)
				send_reg_line();
		end
	endtask

	// raw bytes and tag fragments, including overlapping '+' restarts
	task automatic send_noise();
		int n;
		case ($urandom_range(3))
			0: send_text("+C+CPIN:");
			1: send_text("+CE+CREG:");
			default: begin
				n = $urandom_range(6, 1);
				for (int i = 0; i < n; i++)
					send_byte(8'($urandom));
			end
		endcase
	endtask

	// line cut short by a begin word
	task automatic send_aborted_line();
		if ($urandom_range(1))
			send_text("+CPIN: RE");
		else
			send_text("+CEREG: 1,");
		send_begin($urandom_range(6));
	endtask

	task automatic send_random_sequence();
		int pick;
		pick = $urandom_range(99);
		if (pick < 30)
			send_sim_line();
		else if (pick < 55)
			send_reg_line();
		else if (pick < 67)
			send_timer_burst();
		else if (pick < 75) begin
			repeat ($urandom_range(8, 1))
				send_tick();
		end else if (pick < 85)
			send_noise();
		else if (pick < 91)
			send_aborted_line();
		else if (pick < 95)
			send_word('{KIND_UNUSED, 8'($urandom), $urandom});
		else
			send_begin($urandom_range(4));
	endtask

	task automatic run_phase(input int idle, input int stall, input int goal);
		idle_pct  = idle;
		stall_pct = stall;
		while (words_sent < goal)
			send_random_sequence();
	endtask

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		run_over   = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, idle tick, dropped kind, zero deadline,
		// empty SIM value, registered line, NUL and 0xFF bytes, one-tick expiry
		send_word('{KIND_UNUSED, 8'hff, 32'hffff_ffff});
		send_word('{KIND_TICK, 8'h00, 32'h0000_0000});
		send_begin(32'h0000_0000);
		send_text("+CPIN:");
		send_byte(CH_CR);
		send_begin(32'hffff_ffff);
		send_text("+CREG:,1");
		send_byte(CH_LF);
		send_byte(8'h00);
		send_byte(8'hff);
		send_begin(32'h0000_0001);
		send_tick();

		// no idling; long report hold-off while lines keep coming
		hold_go = 1'b1;
		run_phase(0, 0, 450);

		// sender idles, then waits for every report before going on
		run_phase(59, 0, 900);
		item_valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		@(negedge clk);

		// receiver stalls, then both sides
		run_phase(0, 59, 1325);
		run_phase(33, 33, 1750);

		item_valid <= 1'b0;
		stall_pct = 0;
		for (drain_cycles = 0; drain_cycles < 5000 && pending != 0; drain_cycles++)
			@(posedge clk);
		// leave room for a late word to pass the input and output registers
		repeat (10) @(posedge clk);
		@(negedge clk);
		run_over = 1'b1;
		@(posedge clk);
		@(negedge clk);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
